FILE: rtl/size_class_tile_allocator_macros.svh
// assertion macros for the size class tile allocator checker
// no dependencies; included by the checker module only
`ifndef SIZE_CLASS_TILE_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_TILE_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define SCTA_ASSERT_NOW(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("scta same-cycle check failed");

// next-cycle implication, disabled during reset
`define SCTA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("scta next-cycle check failed");

`endif

FILE: rtl/scta_pkg.sv
// shared constants, types and helper functions for the tile allocator
// no dependencies
package scta_pkg;

	localparam int ATLAS_SIZE    = 2048;
	localparam int MIN_TILE_SIZE = 128;
	localparam int MAX_LAYERS    = 8;
	localparam int ID_COUNT      = 256;
	localparam int SIZE_CLASSES  = 5;

	localparam int SIDE0       = ATLAS_SIZE / MIN_TILE_SIZE;
	localparam int MIN_SHIFT   = $clog2(MIN_TILE_SIZE);
	localparam int COORD_W     = $clog2(SIDE0);
	localparam int CLS_W       = 3;
	localparam int CNT_W       = 12;
	localparam int ADDR_W      = 12;
	localparam int STORE_DEPTH = 2728;
	localparam int LAYER_W     = 3;
	localparam int LCNT_W      = $clog2(MAX_LAYERS + 1);
	localparam int POS_W       = 11;
	localparam int ID_W        = 8;
	localparam int DIM_W       = 12;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef struct packed {
		logic [LAYER_W-1:0] layer;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
	} tile_t;

	typedef struct packed {
		tile_t            tile;
		logic [CLS_W-1:0] cls;
	} id_ent_t;

	typedef enum logic [1:0] {
		CMD_REGISTER   = 2'd0,
		CMD_UNREGISTER = 2'd1,
		CMD_CLEAR      = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_ID_USED    = 3'd1,
		ST_TOO_LARGE  = 3'd2,
		ST_ID_UNKNOWN = 3'd3,
		ST_NO_LAYER   = 3'd4
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACCESS,
		S_DECIDE,
		S_FILL,
		S_POP,
		S_POP_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic classify;
		logic decide;
		logic fill_step;
		logic pop_rd;
		logic pop_wr;
		logic deliver;
	} ctrl_t;

	typedef struct packed {
		logic go_fill;
		logic go_pop;
		logic fill_last;
		logic out_free;
	} dstat_t;

	// list capacity of a class over all layers: tile count drops by a factor of four per class
	function automatic cnt_t cls_cap(input logic [CLS_W-1:0] c);
		return cnt_t'((SIDE0 * SIDE0 * MAX_LAYERS) >> (2 * int'(c)));
	endfunction

	// start of a class region in the free tile store
	function automatic addr_t cls_base(input logic [CLS_W-1:0] c);
		int b;
		int n;
		b = 0;
		for (int k = 0; k < SIZE_CLASSES; k++) begin
			n = SIDE0 >> k;
			if (k < int'(c))
				b = b + n * n * MAX_LAYERS;
		end
		return addr_t'(b);
	endfunction

endpackage

FILE: rtl/size_class_tile_allocator.sv
// top level of the size class tile allocator
// depends on scta_pkg, scta_ctrl and scta_dp
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | command, texture_id, tex_width, tex_height
//  rsp     | out       | rsp_valid / rsp_stall | status, layer_index, tile_x, tile_y, size_class
//
// one transaction at a time; errors, unregister and clear pass through ACCESS, DECIDE and DONE,
// a register served from its free list also through POP and POP_WR; the next request is
// taken once DONE has handed the result to a free output register
// a register that opens a layer first pushes its (16 >> class)^2 new tiles, up to 256,
// one at a time in the FILL state through the single write port of the free tile store
// reset clears lists, id valid bits and layer count at once; no clearing pass
// a stalled result stays in the output register while the next request is taken
module size_class_tile_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [1:0]                     command,
	input  logic [scta_pkg::ID_W-1:0]      texture_id,
	input  logic [scta_pkg::DIM_W-1:0]     tex_width,
	input  logic [scta_pkg::DIM_W-1:0]     tex_height,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [2:0]                     status,
	output logic [scta_pkg::LAYER_W-1:0]   layer_index,
	output logic [scta_pkg::POS_W-1:0]     tile_x,
	output logic [scta_pkg::POS_W-1:0]     tile_y,
	output logic [scta_pkg::CLS_W-1:0]     size_class
);

	scta_pkg::ctrl_t  ctrl;
	scta_pkg::dstat_t dstat;

	scta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.dstat     (dstat),
		.ctrl      (ctrl)
	);

	scta_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.dstat       (dstat),
		.command     (command),
		.texture_id  (texture_id),
		.tex_width   (tex_width),
		.tex_height  (tex_height),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.layer_index (layer_index),
		.tile_x      (tile_x),
		.tile_y      (tile_y),
		.size_class  (size_class)
	);

endmodule

FILE: rtl/scta_ctrl.sv
// controller state machine for the tile allocator
// depends on scta_pkg
module scta_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  scta_pkg::dstat_t   dstat,
	output scta_pkg::ctrl_t    ctrl
);

	scta_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= scta_pkg::S_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			scta_pkg::S_IDLE:   if (req_valid) state_nxt = scta_pkg::S_ACCESS;
			scta_pkg::S_ACCESS: state_nxt = scta_pkg::S_DECIDE;
			scta_pkg::S_DECIDE: begin
				if (dstat.go_fill)
					state_nxt = scta_pkg::S_FILL;
				else if (dstat.go_pop)
					state_nxt = scta_pkg::S_POP;
				else
					state_nxt = scta_pkg::S_DONE;
			end
			scta_pkg::S_FILL:   if (dstat.fill_last) state_nxt = scta_pkg::S_POP;
			scta_pkg::S_POP:    state_nxt = scta_pkg::S_POP_WR;
			scta_pkg::S_POP_WR: state_nxt = scta_pkg::S_DONE;
			scta_pkg::S_DONE:   if (dstat.out_free) state_nxt = scta_pkg::S_IDLE;
			default:            state_nxt = scta_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		req_stall = 1'b1;
		case (state_q)
			scta_pkg::S_IDLE: begin
				req_stall = 1'b0;
				ctrl.capture = req_valid;
			end
			scta_pkg::S_ACCESS: ctrl.classify = 1'b1;
			scta_pkg::S_DECIDE: ctrl.decide = 1'b1;
			scta_pkg::S_FILL:   ctrl.fill_step = 1'b1;
			scta_pkg::S_POP:    ctrl.pop_rd = 1'b1;
			scta_pkg::S_POP_WR: ctrl.pop_wr = 1'b1;
			scta_pkg::S_DONE:   ctrl.deliver = dstat.out_free;
			default:            req_stall = 1'b1;
		endcase
	end

endmodule

FILE: rtl/scta_dp.sv
// datapath: free lists, tile store, id table and result registers
// depends on scta_pkg
module scta_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  scta_pkg::ctrl_t                ctrl,
	output scta_pkg::dstat_t               dstat,
	input  logic [1:0]                     command,
	input  logic [scta_pkg::ID_W-1:0]      texture_id,
	input  logic [scta_pkg::DIM_W-1:0]     tex_width,
	input  logic [scta_pkg::DIM_W-1:0]     tex_height,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [2:0]                     status,
	output logic [scta_pkg::LAYER_W-1:0]   layer_index,
	output logic [scta_pkg::POS_W-1:0]     tile_x,
	output logic [scta_pkg::POS_W-1:0]     tile_y,
	output logic [scta_pkg::CLS_W-1:0]     size_class
);

	// captured request
	logic [1:0]                    cmd_q;
	logic [scta_pkg::ID_W-1:0]     id_q;
	logic [scta_pkg::DIM_W-1:0]    w_q, h_q;
	logic [scta_pkg::CLS_W-1:0]    cls_q;
	logic                          cls_bad_q;

	// id table: valid bits in flops, payload in memory
	logic [scta_pkg::ID_COUNT-1:0] id_vld_q;
	logic                          id_vld_rd_q;
	scta_pkg::id_ent_t             id_mem [scta_pkg::ID_COUNT];
	scta_pkg::id_ent_t             id_rd_q;

	// free lists
	scta_pkg::tile_t               store [scta_pkg::STORE_DEPTH];
	scta_pkg::tile_t               store_rd_q;
	logic                          pop_empty_q;
	scta_pkg::cnt_t                cnt_q [scta_pkg::SIZE_CLASSES];
	scta_pkg::cnt_t                hd_q  [scta_pkg::SIZE_CLASSES];
	logic [scta_pkg::LCNT_W-1:0]   layers_q;
	logic [scta_pkg::COORD_W-1:0]  fx_q, fy_q;

	// result and output registers
	scta_pkg::stat_t               res_stat_q;
	scta_pkg::tile_t               res_tile_q;
	logic [scta_pkg::CLS_W-1:0]    res_cls_q;
	logic                          out_vld_q;
	scta_pkg::stat_t               out_stat_q;
	scta_pkg::tile_t               out_tile_q;
	logic [scta_pkg::CLS_W-1:0]    out_cls_q;

	// combinational
	logic [scta_pkg::DIM_W-1:0]    side;
	logic [scta_pkg::CLS_W-1:0]    cls_c;
	logic                          bad_c;
	logic                          is_unreg_ok;
	logic [scta_pkg::CLS_W-1:0]    act_cls;
	scta_pkg::cnt_t                act_cnt, act_hd, act_cap;
	logic [scta_pkg::CNT_W:0]      pos_sum;
	scta_pkg::cnt_t                pos;
	scta_pkg::addr_t               push_idx, pop_idx;
	logic                          push_en, push_ok;
	scta_pkg::tile_t               push_tile, fill_tile;
	logic [scta_pkg::COORD_W-1:0]  coord_max;
	scta_pkg::cnt_t                hd_inc;

	// smallest class whose side covers the larger dimension
	always_comb begin
		side  = (w_q > h_q) ? w_q : h_q;
		cls_c = '0;
		bad_c = 1'b1;
		for (int c = scta_pkg::SIZE_CLASSES - 1; c >= 0; c--) begin
			if (int'(side) <= (scta_pkg::MIN_TILE_SIZE << c)) begin
				cls_c = scta_pkg::CLS_W'(c);
				bad_c = (scta_pkg::MIN_TILE_SIZE << c) > scta_pkg::ATLAS_SIZE;
			end
		end
	end

	assign is_unreg_ok = ctrl.decide && (cmd_q == scta_pkg::CMD_UNREGISTER) && id_vld_rd_q;
	assign act_cls     = is_unreg_ok ? id_rd_q.cls : cls_q;
	assign act_cnt     = cnt_q[act_cls];
	assign act_hd      = hd_q[act_cls];
	assign act_cap     = scta_pkg::cls_cap(act_cls);

	always_comb begin
		pos_sum = {1'b0, act_hd} + {1'b0, act_cnt};
		if (pos_sum >= {1'b0, act_cap})
			pos = scta_pkg::CNT_W'(pos_sum - {1'b0, act_cap});
		else
			pos = pos_sum[scta_pkg::CNT_W-1:0];
	end

	assign push_idx = scta_pkg::cls_base(act_cls) + scta_pkg::ADDR_W'(pos);
	assign pop_idx  = scta_pkg::cls_base(act_cls) + scta_pkg::ADDR_W'(act_hd);

	assign coord_max = scta_pkg::COORD_W'((scta_pkg::SIDE0 - 1) >> cls_q);
	always_comb begin
		fill_tile.layer = layers_q[scta_pkg::LAYER_W-1:0];
		fill_tile.x = scta_pkg::POS_W'(fx_q) << (scta_pkg::MIN_SHIFT + int'(cls_q));
		fill_tile.y = scta_pkg::POS_W'(fy_q) << (scta_pkg::MIN_SHIFT + int'(cls_q));
	end

	assign push_en   = is_unreg_ok || ctrl.fill_step;
	assign push_tile = is_unreg_ok ? id_rd_q.tile : fill_tile;
	assign push_ok   = push_en && (act_cnt < act_cap);
	assign hd_inc    = (act_hd + 1'b1 >= act_cap) ? '0 : act_hd + 1'b1;

	always_comb begin
		dstat.go_fill   = 1'b0;
		dstat.go_pop    = 1'b0;
		if ((cmd_q == scta_pkg::CMD_REGISTER) && !id_vld_rd_q && !cls_bad_q) begin
			if (act_cnt == '0)
				dstat.go_fill = layers_q < scta_pkg::LCNT_W'(scta_pkg::MAX_LAYERS);
			else
				dstat.go_pop = 1'b1;
		end
		dstat.fill_last = (fx_q == coord_max) && (fy_q == coord_max);
		dstat.out_free  = !out_vld_q || !rsp_stall;
	end

	// payload memories
	always_ff @(posedge clk) begin
		if (push_ok)
			store[push_idx] <= push_tile;
		if (ctrl.pop_rd)
			store_rd_q <= store[pop_idx];
		if (ctrl.classify)
			id_rd_q <= id_mem[id_q];
		if (ctrl.pop_wr)
			id_mem[id_q] <= '{tile: (pop_empty_q ? '0 : store_rd_q), cls: cls_q};
	end

	// request capture and results
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= command;
			id_q  <= texture_id;
			w_q   <= tex_width;
			h_q   <= tex_height;
		end
		if (ctrl.classify) begin
			cls_q     <= cls_c;
			cls_bad_q <= bad_c;
		end
		if (ctrl.pop_rd)
			pop_empty_q <= act_cnt == '0;
		if (ctrl.decide) begin
			res_stat_q <= scta_pkg::ST_OK;
			res_tile_q <= '0;
			res_cls_q  <= '0;
			fx_q       <= '0;
			fy_q       <= '0;
			case (cmd_q)
				scta_pkg::CMD_REGISTER: begin
					if (id_vld_rd_q)
						res_stat_q <= scta_pkg::ST_ID_USED;
					else if (cls_bad_q)
						res_stat_q <= scta_pkg::ST_TOO_LARGE;
					else if (act_cnt == '0 &&
						layers_q >= scta_pkg::LCNT_W'(scta_pkg::MAX_LAYERS)) begin
						res_stat_q <= scta_pkg::ST_NO_LAYER;
						res_cls_q  <= cls_q;
					end
				end
				scta_pkg::CMD_UNREGISTER: begin
					if (!id_vld_rd_q)
						res_stat_q <= scta_pkg::ST_ID_UNKNOWN;
					else begin
						res_tile_q <= id_rd_q.tile;
						res_cls_q  <= id_rd_q.cls;
					end
				end
				default: res_stat_q <= scta_pkg::ST_OK;
			endcase
		end
		if (ctrl.fill_step) begin
			if (fy_q == coord_max) begin
				fy_q <= '0;
				fx_q <= fx_q + 1'b1;
			end else
				fy_q <= fy_q + 1'b1;
		end
		if (ctrl.pop_wr) begin
			res_stat_q <= scta_pkg::ST_OK;
			res_tile_q <= pop_empty_q ? '0 : store_rd_q;
			res_cls_q  <= cls_q;
		end
		if (ctrl.deliver) begin
			out_stat_q <= res_stat_q;
			out_tile_q <= res_tile_q;
			out_cls_q  <= res_cls_q;
		end
	end

	// list bookkeeping, id valid bits, layer count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < scta_pkg::SIZE_CLASSES; c++) begin
				cnt_q[c] <= '0;
				hd_q[c]  <= '0;
			end
			id_vld_q    <= '0;
			id_vld_rd_q <= 1'b0;
			layers_q    <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (ctrl.classify)
				id_vld_rd_q <= id_vld_q[id_q];
			if (ctrl.decide && cmd_q == scta_pkg::CMD_CLEAR) begin
				for (int c = 0; c < scta_pkg::SIZE_CLASSES; c++) begin
					cnt_q[c] <= '0;
					hd_q[c]  <= '0;
				end
				id_vld_q <= '0;
				layers_q <= '0;
			end
			if (push_ok)
				cnt_q[act_cls] <= act_cnt + 1'b1;
			if (is_unreg_ok)
				id_vld_q[id_q] <= 1'b0;
			if (ctrl.fill_step && dstat.fill_last)
				layers_q <= layers_q + 1'b1;
			if (ctrl.pop_rd && act_cnt != '0) begin
				cnt_q[act_cls] <= act_cnt - 1'b1;
				hd_q[act_cls]  <= hd_inc;
			end
			if (ctrl.pop_wr)
				id_vld_q[id_q] <= 1'b1;
			if (ctrl.deliver)
				out_vld_q <= 1'b1;
			else if (!rsp_stall)
				out_vld_q <= 1'b0;
		end
	end

	assign rsp_valid   = out_vld_q;
	assign status      = out_stat_q;
	assign layer_index = out_tile_q.layer;
	assign tile_x      = out_tile_q.x;
	assign tile_y      = out_tile_q.y;
	assign size_class  = out_cls_q;

endmodule

FILE: rtl/scta_checker.sv
// port-level checks for the tile allocator, bound to the top level
// depends on scta_pkg and size_class_tile_allocator_macros.svh
`include "size_class_tile_allocator_macros.svh"

module scta_port_checks (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           rsp_valid,
	input logic                           rsp_stall,
	input logic [2:0]                     status,
	input logic [scta_pkg::LAYER_W-1:0]   layer_index,
	input logic [scta_pkg::POS_W-1:0]     tile_x,
	input logic [scta_pkg::POS_W-1:0]     tile_y,
	input logic [scta_pkg::CLS_W-1:0]     size_class
);

	logic rsp_ok, rsp_err, rsp_err_cls, tile_zero, tile_grid;

	assign rsp_ok      = rsp_valid && status == scta_pkg::ST_OK;
	assign rsp_err     = rsp_valid && status != scta_pkg::ST_OK;
	assign rsp_err_cls = rsp_err && status != scta_pkg::ST_NO_LAYER;
	assign tile_zero   = layer_index == '0 && tile_x == '0 && tile_y == '0;
	assign tile_grid   = tile_x[scta_pkg::MIN_SHIFT-1:0] == '0 &&
		tile_y[scta_pkg::MIN_SHIFT-1:0] == '0;

	// a stalled result is not dropped
	`SCTA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid)

	// error results carry no tile
	`SCTA_ASSERT_NOW(a_err_no_tile, clk, arst_n, rsp_err, tile_zero)

	// tiles sit on the smallest tile grid
	`SCTA_ASSERT_NOW(a_tile_aligned, clk, arst_n, rsp_ok, tile_grid)

	// only an exhausted atlas reports a class with an error
	`SCTA_ASSERT_NOW(a_err_cls, clk, arst_n, rsp_err_cls, size_class == '0)

endmodule

bind size_class_tile_allocator scta_port_checks u_scta_checker (.*);
